// File: hdl/mru_key_list_top_macros.svh
// Assertion macros used by the MRU key list controller
`ifndef MRU_KEY_LIST_TOP_MACROS_SVH
`define MRU_KEY_LIST_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define MKL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MKL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/mkl_pkg.sv
// Package: sizes, command codes and transfer types of the MRU key list
`timescale 1ns / 1ps

package mkl_pkg;

    // Storage sizes
    localparam int DEPTH     = 16;
    localparam int KEY_BITS  = 32;
    localparam int CNT_BITS  = $clog2(DEPTH + 1);
    localparam int IDX_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CAP_BITS  = 5;
    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;

    // Command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_READ   = 2'd3;

    // Result kinds
    localparam logic KIND_ACK   = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    typedef struct packed {
        logic [1:0]  command;
        logic [31:0] key;
    } req_item_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] entry_key;
        logic [3:0]  position;
        logic [4:0]  entry_count;
        logic        hit;
        logic        last;
    } rsp_item_t;

    // Controller to datapath
    typedef struct packed {
        logic load_req;   // capture the accepted request
        logic exec;       // run the command, load the first result
        logic emit_next;  // load the next list entry of a read
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic multi;      // read with more than one entry to list
        logic emit_last;  // next entry to load is the final one
    } dp_status_t;

endpackage

// File: hdl/mkl_ctrl.sv
// Controller: sequences request capture, execution and list read-out
`timescale 1ns / 1ps
`include "mru_key_list_top_macros.svh"

module mkl_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output mkl_pkg::dp_cmd_t    cmd,
    input  mkl_pkg::dp_status_t status
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       out_free;
    logic       req_xfer;

    // Output register can take a new result next cycle
    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = !((state_reg == S_IDLE) && out_free);
    assign req_xfer  = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;

    // Next state and commands
    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_xfer)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec       = 1'b1;
                rsp_valid_next = 1'b1;
                state_next     = status.multi ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    cmd.emit_next  = 1'b1;
                    rsp_valid_next = 1'b1;
                    if (status.emit_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Checks
    `MKL_ASSERT_NEXT(a_accept_to_exec, req_xfer,
                     (state_reg == S_EXEC) && !rsp_valid_reg,
                     "accepted request did not enter execute with a free output")
    `MKL_ASSERT_NEXT(a_exec_gives_result, state_reg == S_EXEC, rsp_valid_reg,
                     "execute did not produce a result")
    `MKL_ASSERT_NEXT(a_emit_holds, (state_reg == S_EMIT) && rsp_stall,
                     (state_reg == S_EMIT) && rsp_valid_reg,
                     "read-out advanced while output stalled")
    `MKL_ASSERT_SAME(a_one_op, 1'b1,
                     $onehot0({cmd.load_req, cmd.exec, cmd.emit_next}),
                     "more than one datapath operation in a cycle")

endmodule

// File: hdl/mkl_dp.sv
// Datapath: key list registers, parallel search and shift, result register
`timescale 1ns / 1ps

module mkl_dp
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  mkl_pkg::req_item_t             req,
    input  logic                           cfg_wen,
    input  logic [mkl_pkg::CAP_BITS-1:0]   cfg_wdata,
    input  mkl_pkg::dp_cmd_t               cmd,
    output mkl_pkg::dp_status_t            status,
    output mkl_pkg::rsp_item_t             rsp
);

    logic [1:0]                      cmd_reg;
    logic [mkl_pkg::KEY_BITS-1:0]    key_reg;
    logic [mkl_pkg::KEY_BITS-1:0]    list_reg [mkl_pkg::DEPTH];
    logic [mkl_pkg::KEY_BITS-1:0]    list_next [mkl_pkg::DEPTH];
    logic [mkl_pkg::CNT_BITS-1:0]    count_reg;
    logic [mkl_pkg::CNT_BITS-1:0]    count_next;
    logic [mkl_pkg::CAP_BITS-1:0]    cap_reg;
    logic [mkl_pkg::IDX_BITS-1:0]    rd_idx_reg;
    logic [mkl_pkg::IDX_BITS-1:0]    rd_idx_next;
    mkl_pkg::rsp_item_t              rsp_reg;
    mkl_pkg::rsp_item_t              rsp_next;

    logic [mkl_pkg::DEPTH-1:0]       match;
    logic [mkl_pkg::DEPTH:0]         seen;
    logic                            hit;
    logic [mkl_pkg::CNT_BITS-1:0]    eff_cap;
    logic [mkl_pkg::CNT_BITS-1:0]    cnt_less;
    logic [mkl_pkg::CNT_BITS-1:0]    rd_pos_inc;
    logic                            update;

    // Effective capacity: zero acts as one, large values clip to the depth
    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = (mkl_pkg::CNT_BITS)'(1);
        end
        else if (32'(cap_reg) > mkl_pkg::DEPTH)
        begin
            eff_cap = (mkl_pkg::CNT_BITS)'(mkl_pkg::DEPTH);
        end
        else
        begin
            eff_cap = (mkl_pkg::CNT_BITS)'(cap_reg);
        end
    end

    // Parallel compare over held entries, prefix of matches
    always_comb
    begin
        seen[0] = 1'b0;
        for (int j = 0; j < mkl_pkg::DEPTH; j++)
        begin
            match[j]    = ((mkl_pkg::CNT_BITS)'(j) < count_reg) && (list_reg[j] == key_reg);
            seen[j + 1] = seen[j] | match[j];
        end
        hit = seen[mkl_pkg::DEPTH];
    end

    assign cnt_less   = hit ? (count_reg - 1'b1) : count_reg;
    assign rd_pos_inc = (mkl_pkg::CNT_BITS)'(rd_idx_reg) + 1'b1;

    // Next list contents and count
    always_comb
    begin
        list_next  = list_reg;
        count_next = count_reg;
        update     = 1'b0;
        case (cmd_reg)
            mkl_pkg::CMD_INSERT:
            begin
                update       = 1'b1;
                list_next[0] = key_reg;
                for (int j = 1; j < mkl_pkg::DEPTH; j++)
                begin
                    list_next[j] = seen[j] ? list_reg[j] : list_reg[j - 1];
                end
                count_next = (cnt_less >= eff_cap) ? eff_cap : (cnt_less + 1'b1);
            end
            mkl_pkg::CMD_REMOVE:
            begin
                update = 1'b1;
                for (int j = 0; j < mkl_pkg::DEPTH - 1; j++)
                begin
                    list_next[j] = seen[j + 1] ? list_reg[j + 1] : list_reg[j];
                end
                count_next = cnt_less;
            end
            mkl_pkg::CMD_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    // Result to load into the output register
    always_comb
    begin
        rsp_next    = rsp_reg;
        rd_idx_next = rd_idx_reg;
        if (cmd.exec)
        begin
            rsp_next.kind        = mkl_pkg::KIND_ACK;
            rsp_next.entry_key   = '0;
            rsp_next.position    = '0;
            rsp_next.entry_count = 5'(count_next);
            rsp_next.hit         = hit && ((cmd_reg == mkl_pkg::CMD_INSERT) ||
                                           (cmd_reg == mkl_pkg::CMD_REMOVE));
            rsp_next.last        = 1'b1;
            rd_idx_next          = (mkl_pkg::IDX_BITS)'(1);
            if ((cmd_reg == mkl_pkg::CMD_READ) && (count_reg != '0))
            begin
                rsp_next.kind      = mkl_pkg::KIND_ENTRY;
                rsp_next.entry_key = 32'(list_reg[0]);
                rsp_next.hit       = 1'b0;
                rsp_next.last      = (count_reg == (mkl_pkg::CNT_BITS)'(1));
            end
        end
        else if (cmd.emit_next)
        begin
            rsp_next.kind        = mkl_pkg::KIND_ENTRY;
            rsp_next.entry_key   = 32'(list_reg[rd_idx_reg]);
            rsp_next.position    = 4'(rd_idx_reg);
            rsp_next.entry_count = 5'(count_reg);
            rsp_next.hit         = 1'b0;
            rsp_next.last        = status.emit_last;
            rd_idx_next          = rd_idx_reg + 1'b1;
        end
    end

    assign status.multi     = (cmd_reg == mkl_pkg::CMD_READ) &&
                              (count_reg > (mkl_pkg::CNT_BITS)'(1));
    assign status.emit_last = (rd_pos_inc == count_reg);
    assign rsp              = rsp_reg;

    // Control registers: count, capacity, read index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            cap_reg    <= mkl_pkg::CAP_RESET;
            rd_idx_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
            if (cfg_wen)
            begin
                cap_reg <= cfg_wdata;
            end
            rd_idx_reg <= rd_idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            cmd_reg <= req.command;
            key_reg <= (mkl_pkg::KEY_BITS)'(req.key);
        end
        if (cmd.exec && update)
        begin
            list_reg <= list_next;
        end
        rsp_reg <= rsp_next;
    end

endmodule

// File: hdl/mru_key_list_top.sv
// Top level of the MRU key list: controller plus datapath
`timescale 1ns / 1ps
// Insert, remove, clear and empty read: the request is captured, then the execute step
// runs the command (search and shift) and loads one result; no request is taken meanwhile.
// Read of N entries: the first entry in the execute step, then one entry per cycle from
// the single read-out index while rsp_stall is low; the next request is taken after the
// last entry. Reset (rst_n, async, active low) empties the list and sets capacity to 16.

module mru_key_list_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  mkl_pkg::req_item_t            req,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output mkl_pkg::rsp_item_t            rsp,
    input  logic                          cfg_wen,
    input  logic [mkl_pkg::CAP_BITS-1:0]  cfg_wdata
);

    mkl_pkg::dp_cmd_t    dp_cmd;
    mkl_pkg::dp_status_t dp_status;

    mkl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (dp_cmd),
        .status    (dp_status)
    );

    mkl_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .rsp       (rsp)
    );

endmodule
